FILE: hw/rtl/spectrum_magnitude_peak_finder_assert.svh
// Assertion macros for the spectrum magnitude peak finder.
`ifndef SPECTRUM_MAGNITUDE_PEAK_FINDER_ASSERT_SVH
`define SPECTRUM_MAGNITUDE_PEAK_FINDER_ASSERT_SVH

// Checked outside reset.
`define SMPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define SMPF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/smpf_pkg.sv
// Types and constants shared by the spectrum magnitude peak finder.
package smpf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = 17;
  localparam int BIN_W      = 9;
  localparam int FREQ_W     = 17;
  localparam int STEP_W     = 8;
  localparam int MUL_W      = 17;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int SUM_W      = 32;
  localparam int RAD_W      = SUM_W + 2;
  localparam int ROOT_STEPS = RAD_W / 2;

  localparam logic [STEP_W-1:0] STEP_RESET = 8'd30;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] bin_imag;
    logic signed [SAMPLE_W-1:0] bin_real;
  } smpf_bin_t;

  typedef struct packed {
    logic [MAG_W-1:0]  magnitude;
    logic [BIN_W-1:0]  bin_number;
    logic              frame_done;
    logic [BIN_W-1:0]  peak_bin;
    logic [MAG_W-1:0]  peak_magnitude;
    logic [FREQ_W-1:0] peak_freq_q8;
  } smpf_result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } smpf_sqrt_stat_t;

endpackage

FILE: hw/rtl/smpf_mul.sv
// Shared signed multiplier with registered product.
module smpf_mul (
  input  logic                              clk,
  input  logic signed [smpf_pkg::MUL_W-1:0]  a,
  input  logic signed [smpf_pkg::MUL_W-1:0]  b,
  output logic signed [smpf_pkg::PROD_W-1:0] p
);
  import smpf_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

FILE: hw/rtl/smpf_isqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
module smpf_isqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [smpf_pkg::RAD_W-1:0]   radicand,
  output smpf_pkg::smpf_sqrt_stat_t    stat,
  output logic [smpf_pkg::MAG_W-1:0]   root
);
  import smpf_pkg::*;

  localparam int CNT_W = $clog2(ROOT_STEPS);
  localparam int REM_W = MAG_W + 1;

  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [REM_W:0]   rem_shift;
  logic [REM_W:0]   trial;
  logic [REM_W:0]   diff;
  logic             take;

  // one compare/subtract per step
  always_comb begin
    rem_shift = {rem[REM_W-2:0], rad[RAD_W-1 -: 2]};
    trial     = {root, 2'b01};
    diff      = rem_shift - trial;
    take      = (rem_shift >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy && cnt == CNT_W'(ROOT_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      cnt  <= cnt + 1'b1;
      if (take) begin
        rem  <= diff[REM_W-1:0];
        root <= {root[MAG_W-2:0], 1'b1};
      end else begin
        rem  <= rem_shift[REM_W-1:0];
        root <= {root[MAG_W-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: hw/rtl/spectrum_magnitude_peak_finder.sv
// Spectrum magnitude peak finder: per-bin magnitude and per-frame peak report.
//
// Bins of a half spectrum come in order, one request per bin, and each gives
// one result: floor(sqrt(4*(re^2+im^2))), the bin index, and on the last bin
// of a frame (index NUM_BINS-1) the peak bin, its magnitude and the peak
// frequency peak_bin * bin_step_q8 in Q8. Bin 0 never competes for the peak;
// ties keep the earliest bin; an all-zero frame reports bin 0, magnitude 0.
// The sequencer holds one bin at a time. A bin makes two passes through the
// shared multiplier for the squares, one add, 17 one-bit steps of the square
// root loop, and on the last bin one more multiplier pass for the frequency.
// The finished result sits in an output register, so the next bin is taken
// while it waits. bin_step_q8 is written through cfg_we/cfg_wdata only while
// idle, the user's duty, unenforced; it applies from the next frame report.
module spectrum_magnitude_peak_finder #(
  parameter int NUM_BINS = 512
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        bin_valid,
  output logic                        bin_ready,
  input  smpf_pkg::smpf_bin_t         bin,
  output logic                        result_valid,
  input  logic                        result_ready,
  output smpf_pkg::smpf_result_t      result,
  input  logic                        cfg_we,
  input  logic [smpf_pkg::STEP_W-1:0] cfg_wdata
);
  import smpf_pkg::*;
  `include "spectrum_magnitude_peak_finder_assert.svh"

  // counter at least as wide as the reported bin fields
  localparam int CW = ($clog2(NUM_BINS) > BIN_W) ? $clog2(NUM_BINS) : BIN_W;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SQ_RE = 3'd1;  // issue re*re
  localparam logic [2:0] S_SQ_IM = 3'd2;  // issue im*im, keep re^2
  localparam logic [2:0] S_SUM   = 3'd3;  // add, start root
  localparam logic [2:0] S_ROOT  = 3'd4;  // wait for root, update peak
  localparam logic [2:0] S_FREQ  = 3'd5;  // issue best_bin*step
  localparam logic [2:0] S_FWAIT = 3'd6;  // take frequency product
  localparam logic [2:0] S_OUT   = 3'd7;  // load output register

  logic [2:0]        state;
  logic [STEP_W-1:0] bin_step_q8;
  logic [CW-1:0]     bin_counter;
  logic [MAG_W-1:0]  best_magnitude;
  logic [CW-1:0]     best_bin;

  logic signed [SAMPLE_W-1:0] re;
  logic signed [SAMPLE_W-1:0] im;
  logic [SUM_W-1:0]           acc;
  logic [MAG_W-1:0]           mag;
  logic [FREQ_W-1:0]          freq;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  logic                sq_start;
  logic [RAD_W-1:0]    sq_radicand;
  smpf_sqrt_stat_t     sq_stat;
  logic [MAG_W-1:0]    sq_root;

  logic last;
  logic out_free;

  assign last      = (bin_counter >= CW'(NUM_BINS - 1));
  assign bin_ready = (state == S_IDLE);
  assign out_free  = !result_valid || result_ready;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = MUL_W'(re);
    mul_b = MUL_W'(re);
    case (state)
      S_SQ_IM: begin
        mul_a = MUL_W'(im);
        mul_b = MUL_W'(im);
      end
      S_FREQ: begin
        mul_a = MUL_W'(best_bin);
        mul_b = MUL_W'(bin_step_q8);
      end
      default: begin
        mul_a = MUL_W'(re);
        mul_b = MUL_W'(re);
      end
    endcase
  end

  // prod holds im^2 in S_SUM; the sum of squares fits in 32 bits
  assign sq_start    = (state == S_SUM);
  assign sq_radicand = {acc + prod[SUM_W-1:0], 2'b00};

  smpf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  smpf_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_radicand),
    .stat     (sq_stat),
    .root     (sq_root)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_step_q8 <= STEP_RESET;
    end else if (cfg_we) begin
      bin_step_q8 <= cfg_wdata;
    end
  end

  // sequencer and frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      bin_counter    <= '0;
      best_magnitude <= '0;
      best_bin       <= '0;
      result_valid   <= 1'b0;
    end else begin
      // a new result load wins over the drain of the old one
      if (state == S_OUT && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (bin_valid) begin
            state <= S_SQ_RE;
          end
        end
        S_SQ_RE: state <= S_SQ_IM;
        S_SQ_IM: state <= S_SUM;
        S_SUM:   state <= S_ROOT;
        S_ROOT: begin
          if (sq_stat.done) begin
            // bin 0 excluded; strict compare keeps the earliest peak
            if (bin_counter != '0 && sq_root > best_magnitude) begin
              best_magnitude <= sq_root;
              best_bin       <= bin_counter;
            end
            state <= last ? S_FREQ : S_OUT;
          end
        end
        S_FREQ:  state <= S_FWAIT;
        S_FWAIT: state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
            if (last) begin
              bin_counter    <= '0;
              best_magnitude <= '0;
              best_bin       <= '0;
            end else begin
              bin_counter <= bin_counter + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (bin_valid && bin_ready) begin
      re <= bin.bin_real;
      im <= bin.bin_imag;
    end
    if (state == S_SQ_IM) begin
      acc <= prod[SUM_W-1:0];
    end
    if (state == S_ROOT && sq_stat.done) begin
      mag <= sq_root;
    end
    if (state == S_FWAIT) begin
      freq <= prod[FREQ_W-1:0];
    end
    if (state == S_OUT && out_free) begin
      result.magnitude  <= mag;
      result.bin_number <= BIN_W'(bin_counter);
      result.frame_done <= last;
      if (last) begin
        result.peak_bin       <= BIN_W'(best_bin);
        result.peak_magnitude <= best_magnitude;
        result.peak_freq_q8   <= freq;
      end else begin
        result.peak_bin       <= '0;
        result.peak_magnitude <= '0;
        result.peak_freq_q8   <= '0;
      end
    end
  end

  `SMPF_ASSERT(a_busy_after_accept, bin_valid && bin_ready |=> !bin_ready, "ready after accept")
  `SMPF_ASSERT(a_done_on_last_bin, result_valid && result.frame_done |-> result.bin_number == BIN_W'(NUM_BINS - 1), "frame_done off last bin")
  `SMPF_ASSERT(a_peak_zero_midframe, result_valid && !result.frame_done |-> result.peak_bin == '0 && result.peak_magnitude == '0 && result.peak_freq_q8 == '0, "peak fields set mid-frame")
  `SMPF_ASSERT(a_root_only_in_wait, sq_stat.done |-> state == S_ROOT, "root done outside wait state")
  `SMPF_ASSERT_ALWAYS(a_reset_clears, rst |=> !result_valid && bin_ready, "reset did not clear")

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the spectrum magnitude peak finder: bin magnitudes and frame peaks.
`timescale 1ns / 1ps

module tb_top;
  import smpf_pkg::*;

  // Full-length frames, same as the block's default.
  localparam int FRAME_BINS = 512;
  // Length of each directed pattern and of each random content stretch.
  localparam int PAT_LEN = 8;
  localparam int STRETCH = 32;

  logic         clk;
  logic         rst = 1'b1;
  logic         bin_valid = 1'b0;
  logic         bin_ready;
  smpf_bin_t    bin = '0;
  logic         result_valid;
  logic         result_ready = 1'b0;
  smpf_result_t result;
  logic         cfg_we = 1'b0;
  logic [STEP_W-1:0] cfg_wdata = '0;

  spectrum_magnitude_peak_finder #(
    .NUM_BINS(FRAME_BINS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .bin_valid(bin_valid),
    .bin_ready(bin_ready),
    .bin(bin),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Bins waiting to be offered, and per-bin results predicted at acceptance.
  smpf_bin_t    pending_bins[$];
  smpf_result_t expected_results[$];
  // Requests queued but whose result has not come back yet.
  int requests_outstanding = 0;
  int error_count = 0;
  int result_count = 0;

  // Idle draws are switched off for one phase to get back-to-back traffic.
  bit sender_idling = 1'b1;
  bit receiver_idling = 1'b1;

  // Shadow of the block state: frame position, running peak, frequency step.
  int unsigned       frame_pos = 0;
  logic [MAG_W-1:0]  best_mag = '0;
  int unsigned       best_pos = 0;
  logic [STEP_W-1:0] step_q8 = STEP_RESET;

  // Magnitude is floor(sqrt(4*(re^2+im^2))), built one root bit at a time
  // from the top; then the peak search and the end-of-frame report.
  function automatic smpf_result_t predict_bin_result(smpf_bin_t b);
    longint       re;
    longint       im;
    longint       radicand;
    longint       root;
    longint       trial;
    smpf_result_t r;
    re = $signed(b.bin_real);
    im = $signed(b.bin_imag);
    radicand = 4 * (re * re + im * im);
    root = 0;
    for (int k = MAG_W - 1; k >= 0; k--) begin
      trial = root | (longint'(1) << k);
      if (trial * trial <= radicand) root = trial;
    end
    r = '0;
    r.magnitude = root[MAG_W-1:0];
    r.bin_number = frame_pos[BIN_W-1:0];
    // Bin 0 (DC) is left out; strict compare keeps the earliest of equal peaks.
    if (frame_pos >= 1 && r.magnitude > best_mag) begin
      best_mag = r.magnitude;
      best_pos = frame_pos;
    end
    if (frame_pos >= FRAME_BINS - 1) begin
      r.frame_done = 1'b1;
      r.peak_bin = best_pos[BIN_W-1:0];
      r.peak_magnitude = best_mag;
      r.peak_freq_q8 = FREQ_W'(best_pos * step_q8);
      frame_pos = 0;
      best_mag = '0;
      best_pos = 0;
    end else begin
      frame_pos++;
    end
    return r;
  endfunction

  // Request driver: takes the next pending bin once the slot is free and its
  // own gap has run out. Prediction happens at the accepting edge.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      bin_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (bin_valid && bin_ready) expected_results.push_back(predict_bin_result(bin));
      if (!bin_valid || bin_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          bin_valid <= 1'b0;
        end else if (pending_bins.size() != 0) begin
          bin <= pending_bins.pop_front();
          bin_valid <= 1'b1;
          send_gap = sender_idling ? $urandom_range(0, 3) : 0;
        end else begin
          bin_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each result against the oldest prediction, then
  // holds ready low for a drawn number of cycles while results are waiting.
  int           recv_hold = 0;
  smpf_result_t want;
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      recv_hold = 0;
    end else begin
      if (result_valid && result_ready) begin
        result_count++;
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected result: mag=%0d bin=%0d", result.magnitude, result.bin_number);
        end else begin
          want = expected_results.pop_front();
          requests_outstanding--;
          if (result.magnitude !== want.magnitude || result.bin_number !== want.bin_number ||
              result.frame_done !== want.frame_done || result.peak_bin !== want.peak_bin ||
              result.peak_magnitude !== want.peak_magnitude ||
              result.peak_freq_q8 !== want.peak_freq_q8) begin
            error_count++;
            if (error_count <= 10) begin
              $display("result %0d expected: mag=%0d bin=%0d done=%0b peak=%0d/%0d freq=%0d",
                       result_count, want.magnitude, want.bin_number, want.frame_done,
                       want.peak_bin, want.peak_magnitude, want.peak_freq_q8);
              $display("result %0d actual:   mag=%0d bin=%0d done=%0b peak=%0d/%0d freq=%0d",
                       result_count, result.magnitude, result.bin_number, result.frame_done,
                       result.peak_bin, result.peak_magnitude, result.peak_freq_q8);
            end
          end
        end
        recv_hold = receiver_idling ? $urandom_range(0, 3) : 0;
      end else if (recv_hold != 0 && result_valid) begin
        recv_hold--;
      end
      result_ready <= (recv_hold == 0);
    end
  end

  task automatic push_bin(input int re, input int im);
    smpf_bin_t b;
    b.bin_real = re[SAMPLE_W-1:0];
    b.bin_imag = im[SAMPLE_W-1:0];
    pending_bins.push_back(b);
    requests_outstanding++;
  endtask

  // Three directed frames, zero outside their pattern:
  //  - pattern at the frame start: huge DC bin that must not win, ties after it
  //  - an all-zero frame, so the report stays at bin 0, magnitude 0
  //  - pattern at the frame end: full-scale corners, tie on the two
  //    mixed-sign corners, peak on the last bin
  int directed_re[3*PAT_LEN] = '{
    -32768, 0, 5, -3, 100, 0, -100, 1,
    0, 0, 0, 0, 0, 0, 0, 0,
    32767, -32768, 0, -1, 1, 32767, -32768, -32768
  };
  int directed_im[3*PAT_LEN] = '{
    -32768, 0, -3, 5, 0, -100, 0, 0,
    0, 0, 0, 0, 0, 0, 0, 0,
    32767, 0, -32768, -1, 1, -32768, 32767, -32768
  };
  int corner_values[6] = '{-32768, -32767, -1, 0, 1, 32767};
  int step_table[4] = '{0, 255, 1, 128};

  initial begin
    int gen_idx;
    int frame_mode;
    int count;
    int re;
    int im;
    int frame;
    int slot;
    gen_idx = 0;
    frame_mode = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Phase 0 runs with the reset step of 30; each later phase writes a step.
    for (int p = 0; p < 7; p++) begin
      if (p != 0) begin
        // Drain before touching the step register; phase lengths are not whole
        // frames, so most writes land mid-frame and apply to the next report.
        while (requests_outstanding != 0) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= (p < 5) ? STEP_W'(step_table[p-1]) : STEP_W'($urandom_range(0, 255));
        @(posedge clk);
        cfg_we <= 1'b0;
        step_q8 = cfg_wdata;
        sender_idling = (p != 3);
        receiver_idling = (p != 3);
      end

      count = (p == 0) ? 600 : $urandom_range(200, 240);
      for (int i = 0; i < count; i++) begin
        if (gen_idx < 3 * FRAME_BINS) begin
          frame = gen_idx / FRAME_BINS;
          slot = gen_idx % FRAME_BINS;
          if (frame == 2) slot = slot - (FRAME_BINS - PAT_LEN);
          if (slot >= 0 && slot < PAT_LEN) begin
            re = directed_re[frame * PAT_LEN + slot];
            im = directed_im[frame * PAT_LEN + slot];
          end else begin
            re = 0;
            im = 0;
          end
        end else begin
          // Content style is chosen per stretch: full random, tiny values that
          // tie often, zeros behind a random first bin, or corner values.
          if (gen_idx % STRETCH == 0) frame_mode = $urandom_range(0, 9);
          if (frame_mode <= 4 || (frame_mode == 7 && gen_idx % STRETCH == 0)) begin
            re = $urandom;
            im = $urandom;
          end else if (frame_mode <= 6) begin
            re = int'($urandom_range(0, 6)) - 3;
            im = int'($urandom_range(0, 6)) - 3;
          end else if (frame_mode == 7) begin
            re = 0;
            im = 0;
          end else begin
            re = corner_values[$urandom_range(0, 5)];
            im = corner_values[$urandom_range(0, 5)];
          end
        end
        push_bin(re, im);
        gen_idx++;
      end
    end

    while (requests_outstanding != 0) @(posedge clk);
    // Room for a stray extra result to show up.
    repeat (40) @(posedge clk);
    error_count += expected_results.size();
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // About ten times the slowest legal run.
  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
